[hw/rtl/itsc_pkg.sv]
// itsc_pkg: shared widths, constants, token type and arithmetic helpers
// for the index-to-string crc matcher. No dependencies.
// Used by itsc_crc_unit, itsc_cell, the top level and the checker.
package itsc_pkg;

    localparam int SLOT_W     = 7;
    localparam int HASH_W     = 32;
    localparam int INDEX_W    = 64;
    localparam int COUNT_W    = 8;
    localparam int IN_DATA_W  = ((SLOT_W + HASH_W + INDEX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + SLOT_W + HASH_W + INDEX_W + 7) / 8) * 8;

    // divide by 26 one 16-bit chunk at a time, msb chunk first
    localparam int CHUNK_W    = 16;
    localparam int CHUNKS     = INDEX_W / CHUNK_W;
    localparam int CHUNK_CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int ALPHA_SIZE = 26;
    localparam int REM_W      = 5;
    localparam int DIV_X_W    = REM_W + CHUNK_W;
    localparam int DIV_SHIFT  = 26;
    localparam int RECIP_W    = 22;
    localparam int PROD_W     = DIV_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / ALPHA_SIZE);

    localparam logic [7:0]        CHAR_A   = 8'h41;
    localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // one item moving along the cell row; slot is the load slot or the match slot
    typedef struct packed {
        logic                valid;
        logic                is_test;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [HASH_W-1:0]   data;
        logic [INDEX_W-1:0]  index;
    } token_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] quo;
        logic [REM_W-1:0]   rem;
    } div_step_t;

    // x < 26 * 2^16; reciprocal estimate is low by at most one
    function automatic div_step_t div26(input logic [DIV_X_W-1:0] x);
        logic [PROD_W-1:0]  prod;
        logic [DIV_X_W-1:0] q_est;
        logic [DIV_X_W-1:0] r_est;
        div_step_t          res;
        prod  = PROD_W'(x) * PROD_W'(DIV_RECIP);
        q_est = prod[DIV_SHIFT +: DIV_X_W];
        r_est = x - (q_est << 4) - (q_est << 3) - (q_est << 1);
        if (r_est >= DIV_X_W'(ALPHA_SIZE))
        begin
            res.quo = CHUNK_W'(q_est + DIV_X_W'(1));
            res.rem = REM_W'(r_est - DIV_X_W'(ALPHA_SIZE));
        end
        else
        begin
            res.quo = CHUNK_W'(q_est);
            res.rem = REM_W'(r_est);
        end
        return res;
    endfunction

    // reflected crc-32, one byte
    function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc_in,
                                                   input logic [7:0]        byte_in);
        logic [HASH_W-1:0] crc;
        crc = crc_in ^ {24'd0, byte_in};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

[hw/rtl/itsc_crc_unit.sv]
// itsc_crc_unit: front end; takes items, turns a test index into letters
// (bijective base 26) and runs the jamcrc over them. Depends on itsc_pkg.
// Emits one token per item into the cell row.
module itsc_crc_unit #(
    parameter int MAX_LETTERS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_cmd,
    input  logic [itsc_pkg::SLOT_W-1:0]      in_slot,
    input  logic [itsc_pkg::HASH_W-1:0]      in_hash,
    input  logic [itsc_pkg::INDEX_W-1:0]     in_index,
    input  logic                             take,
    output itsc_pkg::token_t                 tok
);

    localparam int LET_W = $clog2(MAX_LETTERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_LETTER,
        ST_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [itsc_pkg::INDEX_W-1:0]        n_reg, n_next;
    logic [itsc_pkg::INDEX_W-1:0]        quo_reg, quo_next;
    logic [itsc_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [itsc_pkg::CHUNK_CW-1:0]       chunk_reg, chunk_next;
    logic [itsc_pkg::HASH_W-1:0]         crc_reg, crc_next;
    logic [LET_W-1:0]                    letters_reg, letters_next;
    logic                                is_test_reg, is_test_next;
    logic [itsc_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [itsc_pkg::INDEX_W-1:0]        index_reg, index_next;

    itsc_pkg::div_step_t                 div_res;
    logic [LET_W-1:0]                    letters_inc;

    assign div_res     = itsc_pkg::div26({rem_reg,
                                          n_reg[itsc_pkg::INDEX_W-1 -: itsc_pkg::CHUNK_W]});
    assign letters_inc = letters_reg + LET_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        chunk_next   = chunk_reg;
        crc_next     = crc_reg;
        letters_next = letters_reg;
        is_test_next = is_test_reg;
        slot_next    = slot_reg;
        index_next   = index_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    is_test_next = (in_cmd == itsc_pkg::CMD_TEST);
                    slot_next    = in_slot;
                    index_next   = in_index;
                    n_next       = in_index;
                    letters_next = '0;
                    if (in_cmd == itsc_pkg::CMD_TEST)
                    begin
                        crc_next   = itsc_pkg::CRC_INIT;
                        state_next = ST_START;
                    end
                    else
                    begin
                        crc_next   = in_hash;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_START:
            begin
                if (n_reg < itsc_pkg::INDEX_W'(itsc_pkg::ALPHA_SIZE))
                begin
                    // short index: a single letter, no bijective offset
                    crc_next   = itsc_pkg::crc_byte(crc_reg,
                                     itsc_pkg::CHAR_A + 8'(n_reg[itsc_pkg::REM_W-1:0]));
                    state_next = ST_DONE;
                end
                else
                begin
                    n_next     = n_reg - itsc_pkg::INDEX_W'(1);
                    rem_next   = '0;
                    chunk_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                n_next     = n_reg << itsc_pkg::CHUNK_W;
                quo_next   = {quo_reg[itsc_pkg::INDEX_W-itsc_pkg::CHUNK_W-1:0], div_res.quo};
                rem_next   = div_res.rem;
                chunk_next = chunk_reg + itsc_pkg::CHUNK_CW'(1);
                if (chunk_reg == itsc_pkg::CHUNK_CW'(itsc_pkg::CHUNKS - 1))
                    state_next = ST_LETTER;
            end
            ST_LETTER:
            begin
                crc_next     = itsc_pkg::crc_byte(crc_reg, itsc_pkg::CHAR_A + 8'(rem_reg));
                letters_next = letters_inc;
                n_next       = quo_reg - itsc_pkg::INDEX_W'(1);
                rem_next     = '0;
                chunk_next   = '0;
                if ((quo_reg != '0) && (32'(letters_inc) < MAX_LETTERS))
                    state_next = ST_DIV;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        chunk_reg   <= chunk_next;
        crc_reg     <= crc_next;
        letters_reg <= letters_next;
        is_test_reg <= is_test_next;
        slot_reg    <= slot_next;
        index_reg   <= index_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        tok.valid   = (state_reg == ST_DONE);
        tok.is_test = is_test_reg;
        tok.hit     = 1'b0;
        tok.slot    = is_test_reg ? '0 : slot_reg;
        tok.data    = crc_reg;
        tok.index   = index_reg;
    end

endmodule

[hw/rtl/itsc_cell.sv]
// itsc_cell: one slot of the target row; holds one target hash, stores it
// on a matching load token and marks a passing test token on a match.
// Depends on itsc_pkg.
module itsc_cell #(
    parameter int CELL_ID = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              enable,
    input  itsc_pkg::token_t  tok_in,
    output itsc_pkg::token_t  tok_out
);

    localparam logic [31:0] CELL_ID_VEC = CELL_ID;

    logic [itsc_pkg::HASH_W-1:0] target_reg;
    logic                        valid_reg, valid_next;
    itsc_pkg::token_t            tok_reg, tok_next;
    logic                        slot_match;
    logic                        load_here;

    assign slot_match = (32'(tok_in.slot) == CELL_ID_VEC);
    assign load_here  = advance && tok_in.valid && !tok_in.is_test && slot_match;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = advance ? tok_in.valid : valid_reg;
        if (tok_in.valid && tok_in.is_test && !tok_in.hit && enable
            && (target_reg == tok_in.data))
        begin
            tok_next.hit  = 1'b1;
            tok_next.slot = CELL_ID_VEC[itsc_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            tok_reg <= tok_next;
        if (load_here)
            target_reg <= tok_in.data;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

[hw/rtl/index_to_string_crc_matcher.sv]
// Index-to-string crc matcher: loads target hashes, tests indexes as letter strings.
// The front end takes one item at a time and accepts no new one until its token
// has moved into the cell row; it divides by 26 one 16-bit chunk per cycle.
// A result passes the front end, a register in each of the TARGET_SLOTS cells and
// then the output register. Reset (rst_n, async, low) clears control state and
// target_count; the target table holds no defined value until loaded.
module index_to_string_crc_matcher #(
    parameter int TARGET_SLOTS = 128,
    parameter int MAX_LETTERS  = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // target_slot, target_hash, search_index, zero pad
    input  logic [itsc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // hit, match_slot, crc_value, index_echo
    output logic [itsc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [itsc_pkg::COUNT_W-1:0]         cfg_wdata
);

    localparam int HASH_LSB  = itsc_pkg::SLOT_W;
    localparam int INDEX_LSB = itsc_pkg::SLOT_W + itsc_pkg::HASH_W;

    logic [itsc_pkg::COUNT_W-1:0]     target_count_reg, target_count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [itsc_pkg::OUT_DATA_W-1:0]  out_data_reg;

    itsc_pkg::token_t                 chain [0:TARGET_SLOTS];
    itsc_pkg::token_t                 end_tok;
    logic [TARGET_SLOTS-1:0]          cell_en;
    logic                             advance;
    logic                             end_result;

    itsc_crc_unit #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_crc_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_slot  (s_axis_tdata[itsc_pkg::SLOT_W-1:0]),
        .in_hash  (s_axis_tdata[HASH_LSB +: itsc_pkg::HASH_W]),
        .in_index (s_axis_tdata[INDEX_LSB +: itsc_pkg::INDEX_W]),
        .take     (advance),
        .tok      (chain[0])
    );

    for (genvar k = 0; k < TARGET_SLOTS; k++)
    begin : g_cell
        assign cell_en[k] = (32'(target_count_reg) > 32'(k));

        itsc_cell #(
            .CELL_ID (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .enable  (cell_en[k]),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign end_tok    = chain[TARGET_SLOTS];
    assign end_result = end_tok.valid && end_tok.is_test;
    // whole row stalls only when a finished result meets a full output register that is not taken
    assign advance    = !(end_result && out_valid_reg && !m_axis_tready);

    always_comb
    begin
        target_count_next = cfg_we ? cfg_wdata : target_count_reg;
        if (advance && end_result)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            target_count_reg <= target_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && end_result)
            out_data_reg <= {end_tok.index, end_tok.data, end_tok.slot, end_tok.hit};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hw/rtl/itsc_checker.sv]
// itsc_checker: port-level assertions for the index-to-string crc matcher,
// attached to the top level by the bind below. Depends on itsc_pkg.
module itsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [itsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a miss reports slot zero
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[itsc_pkg::SLOT_W:1] == '0)
        else $error("miss with nonzero match slot");

    // front end is busy in the cycle after any input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

endmodule

bind index_to_string_crc_matcher itsc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/index_to_string_crc_matcher_tb.sv]
// Testbench for index_to_string_crc_matcher: random and directed load/test traffic,
// checked against a scoreboard that predicts hit, match slot and JAMCRC per test.
// Depends on itsc_pkg and the index_to_string_crc_matcher top level only.
`timescale 1ns / 100ps

module index_to_string_crc_matcher_tb;

    localparam int  SLOTS        = 128;
    localparam int  POOL_SIZE    = 16;
    localparam int  SETTLE_CYCLES = 400;
    localparam int  HOLD_CYCLES  = 1000;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  IDLE_PCT     = 14;

    typedef struct packed {
        logic                         hit;
        logic [itsc_pkg::SLOT_W-1:0]  slot;
        logic [itsc_pkg::HASH_W-1:0]  crc;
        logic [itsc_pkg::INDEX_W-1:0] index;
    } match_result_t;

    class crc_match_scoreboard;
        logic [itsc_pkg::HASH_W-1:0]  target_copy [SLOTS];
        logic [itsc_pkg::COUNT_W-1:0] count_copy;
        match_result_t                pending_results [$];
        int                           mismatches;

        function new();
            foreach (target_copy[k])
                target_copy[k] = '0;
            count_copy = '0;
            mismatches = 0;
        endfunction

        function void set_count(input logic [itsc_pkg::COUNT_W-1:0] value);
            count_copy = value;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function logic [itsc_pkg::HASH_W-1:0] crc_add_char(
            input logic [itsc_pkg::HASH_W-1:0] crc,
            input logic [7:0]                  ch);
            logic [itsc_pkg::HASH_W-1:0] r;
            r = crc ^ {24'h0, ch};
            repeat (8)
                r = r[0] ? ((r >> 1) ^ itsc_pkg::CRC_POLY) : (r >> 1);
            return r;
        endfunction

        // bijective base 26, least significant letter first, no final inversion
        function logic [itsc_pkg::HASH_W-1:0] jamcrc_of_index(
            input logic [itsc_pkg::INDEX_W-1:0] n);
            logic [itsc_pkg::HASH_W-1:0]  crc;
            logic [itsc_pkg::INDEX_W-1:0] m;
            logic [itsc_pkg::INDEX_W-1:0] rest;
            int                           letters;
            crc     = itsc_pkg::CRC_INIT;
            rest    = n;
            letters = 0;
            if (rest < itsc_pkg::INDEX_W'(itsc_pkg::ALPHA_SIZE))
                return crc_add_char(crc, itsc_pkg::CHAR_A + 8'(rest));
            while (rest != '0 && letters < 14)
            begin
                m       = rest - 1;
                crc     = crc_add_char(crc, itsc_pkg::CHAR_A
                              + 8'(m % itsc_pkg::INDEX_W'(itsc_pkg::ALPHA_SIZE)));
                rest    = m / itsc_pkg::INDEX_W'(itsc_pkg::ALPHA_SIZE);
                letters = letters + 1;
            end
            return crc;
        endfunction

        function void note_input(input logic                         cmd,
                                 input logic [itsc_pkg::SLOT_W-1:0]  slot,
                                 input logic [itsc_pkg::HASH_W-1:0]  hash,
                                 input logic [itsc_pkg::INDEX_W-1:0] index);
            match_result_t res;
            int            limit;
            if (cmd == itsc_pkg::CMD_LOAD)
            begin
                target_copy[slot] = hash;
                return;
            end
            res.crc   = jamcrc_of_index(index);
            res.index = index;
            res.hit   = 1'b0;
            res.slot  = '0;
            limit = (int'(count_copy) > SLOTS) ? SLOTS : int'(count_copy);
            for (int k = 0; k < limit; k++)
            begin
                if (!res.hit && target_copy[k] == res.crc)
                begin
                    res.hit  = 1'b1;
                    res.slot = itsc_pkg::SLOT_W'(k);
                end
            end
            pending_results.push_back(res);
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
            mismatches = mismatches + 1;
        endtask

        task check_result(input logic [itsc_pkg::OUT_DATA_W-1:0] bus);
            match_result_t got;
            match_result_t want;
            // tdata holds hit in the lowest bit, so the struct order is reversed
            got.hit   = bus[0];
            got.slot  = bus[1 +: itsc_pkg::SLOT_W];
            got.crc   = bus[1+itsc_pkg::SLOT_W +: itsc_pkg::HASH_W];
            got.index = bus[1+itsc_pkg::SLOT_W+itsc_pkg::HASH_W +: itsc_pkg::INDEX_W];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, index", got.index, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.hit !== want.hit)
                report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.slot !== want.slot)
                report_mismatch("match_slot", 64'(got.slot), 64'(want.slot));
            if (got.crc !== want.crc)
                report_mismatch("crc_value", 64'(got.crc), 64'(want.crc));
            if (got.index !== want.index)
                report_mismatch("index_echo", got.index, want.index);
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // target_slot, target_hash, search_index, zero pad
    logic [itsc_pkg::IN_DATA_W-1:0]    s_axis_tdata;
    // cmd
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // hit, match_slot, crc_value, index_echo
    logic [itsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              cfg_we;
    logic [itsc_pkg::COUNT_W-1:0]      cfg_wdata;

    crc_match_scoreboard               sb;
    logic [itsc_pkg::INDEX_W-1:0]      hit_pool [POOL_SIZE];
    bit                                no_idle   = 1'b0;
    bit                                hold_req  = 1'b0;
    bit                                hold_done = 1'b0;
    int                                cycle_count = 0;

    index_to_string_crc_matcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else if (no_idle)
                m_axis_tready = 1'b1;
            else
                m_axis_tready = ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // entered just after a rising edge, returns just after the accepting edge
    task automatic issue_command(input logic                         cmd,
                                 input logic [itsc_pkg::SLOT_W-1:0]  slot,
                                 input logic [itsc_pkg::HASH_W-1:0]  hash,
                                 input logic [itsc_pkg::INDEX_W-1:0] index);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = itsc_pkg::IN_DATA_W'({index, hash, slot});
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        sb.note_input(cmd, slot, hash, index);
    endtask

    task automatic test_index(input logic [itsc_pkg::INDEX_W-1:0] index);
        issue_command(itsc_pkg::CMD_TEST, itsc_pkg::SLOT_W'($urandom),
                      itsc_pkg::HASH_W'($urandom), index);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        // a trailing load may still be walking the cell row
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_count(input logic [itsc_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        sb.set_count(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [itsc_pkg::INDEX_W-1:0] random_index();
        logic [itsc_pkg::INDEX_W-1:0] full;
        logic [itsc_pkg::INDEX_W-1:0] boundary;
        logic [itsc_pkg::INDEX_W-1:0] power;
        int                           pick;
        int                           letters;
        full = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return hit_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 45)
            return itsc_pkg::INDEX_W'($urandom_range(0, itsc_pkg::ALPHA_SIZE - 1));
        if (pick < 60)
        begin
            // last index of an L-letter string, and its neighbors
            letters  = $urandom_range(1, 13);
            boundary = '0;
            power    = 1;
            for (int k = 0; k < letters; k++)
            begin
                power    = power * itsc_pkg::INDEX_W'(itsc_pkg::ALPHA_SIZE);
                boundary = boundary + power;
            end
            return boundary + itsc_pkg::INDEX_W'($urandom_range(0, 2)) - 1;
        end
        if (pick < 80)
            return full & ((64'h1 << $urandom_range(1, 63)) - 1);
        return full;
    endfunction

    task automatic random_item();
        logic [itsc_pkg::SLOT_W-1:0]  slot;
        logic [itsc_pkg::HASH_W-1:0]  hash;
        logic [itsc_pkg::INDEX_W-1:0] index;
        slot  = itsc_pkg::SLOT_W'($urandom);
        hash  = itsc_pkg::HASH_W'($urandom);
        index = {$urandom, $urandom};
        if (hold_req && !hold_done)
            // short strings fill the row fastest while the output is held
            issue_command(itsc_pkg::CMD_TEST, slot, hash,
                          itsc_pkg::INDEX_W'($urandom_range(0, itsc_pkg::ALPHA_SIZE - 1)));
        else if ($urandom_range(0, 99) < 15)
        begin
            if ($urandom_range(0, 9) < 6)
                hash = sb.jamcrc_of_index(hit_pool[$urandom_range(0, POOL_SIZE - 1)]);
            issue_command(itsc_pkg::CMD_LOAD, slot, hash, index);
        end
        else
            issue_command(itsc_pkg::CMD_TEST, slot, hash, random_index());
    endtask

    initial
    begin
        logic [itsc_pkg::COUNT_W-1:0] phase_counts [9];
        logic [itsc_pkg::HASH_W-1:0]  hash;
        int                           phase_items;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = itsc_pkg::CMD_LOAD;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        sb = new();

        for (int k = 0; k < POOL_SIZE; k++)
        begin
            if (k < 4)
                hit_pool[k] = itsc_pkg::INDEX_W'($urandom_range(0,
                                                                itsc_pkg::ALPHA_SIZE - 1));
            else
                hit_pool[k] = {$urandom, $urandom} & ((64'h1 << $urandom_range(5, 63)) - 1);
        end

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // count is zero out of reset: every test misses
        test_index(64'd0);
        test_index(64'd1);
        test_index(64'd25);
        test_index(64'd26);
        test_index(64'd27);
        test_index(64'd51);
        test_index(64'd52);
        test_index(64'd53);
        test_index(64'd701);
        test_index(64'd702);
        test_index(64'd703);
        test_index(64'd18277);
        test_index(64'd18278);
        test_index(64'hFFFF_FFFF_FFFF_FFFF);
        test_index(64'h8000_0000_0000_0000);
        test_index(64'h5555_5555_5555_5555);
        test_index(64'hAAAA_AAAA_AAAA_AAAA);
        issue_command(itsc_pkg::CMD_LOAD, 7'd0, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_command(itsc_pkg::CMD_LOAD, 7'd127, 32'hFFFF_FFFF, 64'd0);

        // fill every slot so any count compares only loaded entries
        for (int k = 0; k < SLOTS; k++)
        begin
            hash = itsc_pkg::HASH_W'($urandom);
            if (k % 8 == 3)
                hash = sb.jamcrc_of_index(hit_pool[k / 8]);
            else if (k == 0)
                hash = sb.jamcrc_of_index(hit_pool[POOL_SIZE - 1]);
            else if (k == 1)
                hash = 32'h0000_0000;
            else if (k == 2)
                hash = 32'hFFFF_FFFF;
            else if (k == SLOTS - 1)
                hash = sb.jamcrc_of_index(hit_pool[0]);
            issue_command(itsc_pkg::CMD_LOAD, itsc_pkg::SLOT_W'(k), hash,
                          {$urandom, $urandom});
        end

        phase_counts[0] = 8'd128;
        phase_counts[1] = 8'd1;
        phase_counts[2] = 8'd255;
        phase_counts[3] = 8'd0;
        phase_counts[4] = 8'd127;
        phase_counts[5] = 8'd64;
        phase_counts[6] = 8'd200;
        phase_counts[7] = itsc_pkg::COUNT_W'($urandom_range(0, 255));
        phase_counts[8] = itsc_pkg::COUNT_W'($urandom_range(1, 128));

        for (int p = 0; p < 9; p++)
        begin
            wait_drained();
            write_count(phase_counts[p]);
            no_idle     = (p == 4);
            phase_items = (p == 0) ? 180 : 90;
            for (int i = 0; i < phase_items; i++)
            begin
                if (p == 0 && i == 10)
                    hold_req = 1'b1;
                random_item();
            end
        end
        no_idle = 1'b0;

        wait_drained();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
